/* sv/qer_pkg.sv */
// shared types and constants for the quadratic equation roots block
package qer_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CW = 32;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_A_ZERO = 2'd1;
	localparam logic [1:0] ST_NO_REAL = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
	} coef_t;

	typedef struct packed {
		logic signed [CW-1:0] root_plus;
		logic signed [CW-1:0] root_minus;
		logic [1:0] status;
		logic saturated;
	} roots_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic [1:0] status;
		logic a_neg;
		logic neg_p;
		logic neg_m;
		logic signed [CW-1:0] b;
		logic [CW:0] dvs;
	} side_t;
endpackage

/* sv/qer_chan_if.sv */
// valid/ready channel carrying one payload beat
interface qer_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/quadratic_equation_roots.sv */
// Quadratic equation solver, Q16.16 coefficients in, two roots out. Fully
// pipelined: one coefficient set is taken every cycle while the output is not
// stalled, with one register per stage: two input stages, the discriminant,
// the 34 stages of the bit-per-stage square root, the numerator stage, the
// 36+FRAC_BITS stages of the bit-per-stage dividers and the output register.
// The whole pipeline advances while the output is empty or taken, so a stall
// at the output holds every beat in place.
module quadratic_equation_roots #(
	parameter int FRAC_BITS = qer_pkg::FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	qer_chan_if.sink in_ch,
	qer_chan_if.source out_ch
);
	localparam int CW = qer_pkg::CW;
	localparam int SQ = 34;
	localparam int DW = 36 + FRAC_BITS;

	logic en;
	logic out_vld_q;
	qer_pkg::roots_t out_q;

	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: magnitudes and signs
	logic vld_s1;
	logic [CW-1:0] ma_s1, mb_s1, mc_s1;
	logic a_neg_s1, c_neg_s1, a_zero_s1;
	logic signed [CW-1:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= in_ch.data.coef_a[CW-1] ? CW'(-in_ch.data.coef_a) : in_ch.data.coef_a;
			mb_s1 <= in_ch.data.coef_b[CW-1] ? CW'(-in_ch.data.coef_b) : in_ch.data.coef_b;
			mc_s1 <= in_ch.data.coef_c[CW-1] ? CW'(-in_ch.data.coef_c) : in_ch.data.coef_c;
			a_neg_s1 <= in_ch.data.coef_a[CW-1];
			c_neg_s1 <= in_ch.data.coef_c[CW-1];
			a_zero_s1 <= (in_ch.data.coef_a == '0);
			b_s1 <= in_ch.data.coef_b;
		end
	end

	// stage 2: products
	logic vld_s2;
	logic [2*CW-1:0] bb_s2, ac_s2;
	logic same_s2, a_zero_s2, a_neg_s2;
	logic signed [CW-1:0] b_s2;
	logic [CW-1:0] ma_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2 <= mb_s1 * mb_s1;
			ac_s2 <= ma_s1 * mc_s1;
			same_s2 <= (a_neg_s1 == c_neg_s1);
			a_zero_s2 <= a_zero_s1;
			a_neg_s2 <= a_neg_s1;
			b_s2 <= b_s1;
			ma_s2 <= ma_s1;
		end
	end

	// stage 3: discriminant
	logic [67:0] bb_w, ac4_w;
	qer_pkg::side_t side_d;
	logic [67:0] delta_d;

	assign bb_w = {4'b0, bb_s2};
	assign ac4_w = {2'b0, ac_s2, 2'b0};

	always_comb begin
		side_d = '0;
		side_d.a_neg = a_neg_s2;
		side_d.b = b_s2;
		side_d.dvs = {ma_s2, 1'b0};
		delta_d = '0;
		if (a_zero_s2) begin
			side_d.status = qer_pkg::ST_A_ZERO;
		end else if (!same_s2) begin
			side_d.status = qer_pkg::ST_OK;
			delta_d = bb_w + ac4_w;
		end else if (bb_w < ac4_w) begin
			side_d.status = qer_pkg::ST_NO_REAL;
		end else begin
			side_d.status = qer_pkg::ST_OK;
			delta_d = bb_w - ac4_w;
		end
	end

	// square root, one result bit per stage
	logic sq_vld_s [0:SQ];
	logic [67:0] sq_rem_s [0:SQ];
	logic [SQ-1:0] sq_root_s [0:SQ];
	qer_pkg::side_t sq_side_s [0:SQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else if (en) sq_vld_s[0] <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0] <= delta_d;
			sq_root_s[0] <= '0;
			sq_side_s[0] <= side_d;
		end
	end

	for (genvar k = 1; k <= SQ; k++) begin : g_sq
		localparam int I = SQ - k;
		logic [67:0] trial;
		logic take;
		assign trial = ({34'b0, sq_root_s[k-1]} << (I + 1)) + (68'd1 << (2 * I));
		assign take = (trial <= sq_rem_s[k-1]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k] <= 1'b0;
			else if (en) sq_vld_s[k] <= sq_vld_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k] <= take ? sq_rem_s[k-1] - trial : sq_rem_s[k-1];
				sq_root_s[k] <= take ? (sq_root_s[k-1] | (SQ'(1) << I)) : sq_root_s[k-1];
				sq_side_s[k] <= sq_side_s[k-1];
			end
		end
	end

	// numerators -b +/- s as magnitude and sign
	logic signed [36:0] np_w, nm_w;
	assign np_w = -37'(sq_side_s[SQ].b) + $signed({3'b0, sq_root_s[SQ]});
	assign nm_w = -37'(sq_side_s[SQ].b) - $signed({3'b0, sq_root_s[SQ]});

	qer_pkg::side_t dv_side_d;
	always_comb begin
		dv_side_d = sq_side_s[SQ];
		dv_side_d.neg_p = np_w[36] ^ sq_side_s[SQ].a_neg;
		dv_side_d.neg_m = nm_w[36] ^ sq_side_s[SQ].a_neg;
	end

	logic dv_vld_s [0:DW];
	logic [CW:0] dv_rp_s [0:DW];
	logic [CW:0] dv_rm_s [0:DW];
	logic [DW-1:0] dv_np_s [0:DW];
	logic [DW-1:0] dv_nm_s [0:DW];
	qer_pkg::side_t dv_side_s [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_s[0] <= 1'b0;
		else if (en) dv_vld_s[0] <= sq_vld_s[SQ];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dv_rp_s[0] <= '0;
			dv_rm_s[0] <= '0;
			dv_np_s[0] <= DW'(np_w[36] ? 36'(-np_w) : 36'(np_w)) << FRAC_BITS;
			dv_nm_s[0] <= DW'(nm_w[36] ? 36'(-nm_w) : 36'(nm_w)) << FRAC_BITS;
			dv_side_s[0] <= dv_side_d;
		end
	end

	// two restoring dividers, one quotient bit per stage
	for (genvar j = 1; j <= DW; j++) begin : g_dv
		logic [CW+1:0] tp, tm, dd;
		logic gp, gm;
		assign dd = {1'b0, dv_side_s[j-1].dvs};
		assign tp = {dv_rp_s[j-1], dv_np_s[j-1][DW-1]};
		assign tm = {dv_rm_s[j-1], dv_nm_s[j-1][DW-1]};
		assign gp = (tp >= dd);
		assign gm = (tm >= dd);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[j] <= 1'b0;
			else if (en) dv_vld_s[j] <= dv_vld_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rp_s[j] <= gp ? (CW+1)'(tp - dd) : tp[CW:0];
				dv_rm_s[j] <= gm ? (CW+1)'(tm - dd) : tm[CW:0];
				dv_np_s[j] <= {dv_np_s[j-1][DW-2:0], gp};
				dv_nm_s[j] <= {dv_nm_s[j-1][DW-2:0], gm};
				dv_side_s[j] <= dv_side_s[j-1];
			end
		end
	end

	// sign, clamp and status gating
	function automatic logic [CW:0] clamp_root(input logic [DW-1:0] q, input logic neg);
		logic [CW:0] r;
		if (!neg) begin
			if (q > DW'(33'h0_7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, q[CW-1:0]};
		end else begin
			if (q > DW'(33'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, CW'(-q[CW-1:0])};
		end
		return r;
	endfunction

	logic [CW:0] rp_w, rm_w;
	qer_pkg::side_t fin;
	assign fin = dv_side_s[DW];
	assign rp_w = clamp_root(dv_np_s[DW], fin.neg_p);
	assign rm_w = clamp_root(dv_nm_s[DW], fin.neg_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_vld_s[DW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.status <= fin.status;
			if (fin.status == qer_pkg::ST_OK) begin
				out_q.root_plus <= rp_w[CW-1:0];
				out_q.root_minus <= rm_w[CW-1:0];
				out_q.saturated <= rp_w[CW] | rm_w[CW];
			end else begin
				out_q.root_plus <= '0;
				out_q.root_minus <= '0;
				out_q.saturated <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;
endmodule

/* sv/qer_check.sv */
// port-level assertions for the quadratic equation roots block
module qer_check (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input qer_pkg::roots_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != qer_pkg::ST_OK |->
		out_data.root_plus == '0 && out_data.root_minus == '0 && !out_data.saturated)
		else $error("roots not cleared on failed status");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == qer_pkg::ST_OK ||
		out_data.status == qer_pkg::ST_A_ZERO || out_data.status == qer_pkg::ST_NO_REAL)
		else $error("unknown status code");
endmodule

bind quadratic_equation_roots qer_check u_qer_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);

/* tb/tb_quadratic_equation_roots.sv */
// testbench for quadratic_equation_roots: directed and random sets against a predictor
`timescale 1ns / 1ps

module tb_quadratic_equation_roots;
	localparam int CW = qer_pkg::CW;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
	localparam logic signed [CW-1:0] MAX_Q = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] MIN_Q = 32'sh8000_0000;

	logic clk;
	logic arst_n;

	qer_chan_if #(.T(qer_pkg::coef_t)) in_ch ();
	qer_chan_if #(.T(qer_pkg::roots_t)) out_ch ();

	quadratic_equation_roots dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	qer_pkg::roots_t pending_roots[$];
	int errors = 0;
	int stall_count = 0;
	bit idle_en = 1'b1;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one root: trunc(num * 2^FRAC_BITS / (2a)), clamped; bit 32 is the clamp flag
	function automatic logic [32:0] divide_root(longint num, longint a);
		logic [63:0] q;
		logic [63:0] mnum;
		logic [63:0] ma;
		bit neg;
		mnum = (num < 0) ? -num : num;
		ma = (a < 0) ? -a : a;
		q = (mnum << qer_pkg::FRAC_BITS) / (ma * 2);
		neg = (num < 0) != (a < 0);
		if (!neg) begin
			if (q > 64'h7FFF_FFFF)
				return {1'b1, 32'h7FFF_FFFF};
			return {1'b0, q[31:0]};
		end
		if (q > 64'h8000_0000)
			return {1'b1, 32'h8000_0000};
		return {1'b0, 32'(-q)};
	endfunction

	function automatic qer_pkg::roots_t predict_roots(qer_pkg::coef_t x);
		qer_pkg::roots_t r;
		longint a, b, c;
		logic [63:0] ma, mb, mc;
		logic [67:0] bb, ac4, disc, t;
		logic [33:0] s;
		logic [32:0] rp, rm;
		r = '0;
		a = x.coef_a;
		b = x.coef_b;
		c = x.coef_c;
		if (a == 0) begin
			r.status = qer_pkg::ST_A_ZERO;
			return r;
		end
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		mc = (c < 0) ? -c : c;
		bb = {4'b0, mb * mb};
		ac4 = {4'b0, ma * mc} << 2;
		if ((a < 0) != (c < 0)) begin
			disc = bb + ac4;
		end else if (bb < ac4) begin
			r.status = qer_pkg::ST_NO_REAL;
			return r;
		end else begin
			disc = bb - ac4;
		end
		s = '0;
		for (int i = 33; i >= 0; i--) begin
			t = {34'b0, s | (34'b1 << i)};
			if (t * t <= disc)
				s = t[33:0];
		end
		rp = divide_root(-b + longint'(s), a);
		rm = divide_root(-b - longint'(s), a);
		r.root_plus = rp[31:0];
		r.root_minus = rm[31:0];
		r.status = qer_pkg::ST_OK;
		r.saturated = rp[32] | rm[32];
		return r;
	endfunction

	task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
			logic signed [CW-1:0] c);
		qer_pkg::coef_t x;
		x.coef_a = a;
		x.coef_b = b;
		x.coef_c = c;
		while (idle_en && $urandom_range(99) < 8) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= x;
		do @(posedge clk); while (!in_ch.ready);
		pending_roots.push_back(predict_roots(x));
		@(negedge clk);
	endtask

	// mostly modest magnitudes so that real roots and in-range results are common
	function automatic logic signed [CW-1:0] rand_coef();
		logic signed [CW-1:0] v;
		v = $urandom;
		case ($urandom_range(3))
			0: return v;
			1: return v >>> $urandom_range(20, 4);
			2: return v >>> 12;
			default: return v >>> 8;
		endcase
	endfunction

	task automatic test_directed();
		send_coefs(0, ONE, ONE);
		send_coefs(0, MIN_Q, MAX_Q);
		send_coefs(ONE, 0, ONE);
		send_coefs(ONE, 2 * ONE, ONE);
		send_coefs(-ONE, 2 * ONE, -ONE);
		send_coefs(ONE, 0, -4 * ONE);
		send_coefs(2 * ONE, -3 * ONE, -5 * ONE);
		send_coefs(1, 0, MIN_Q);
		send_coefs(-1, 0, MAX_Q);
		send_coefs(1, MAX_Q, 0);
		send_coefs(1, MIN_Q, 0);
		send_coefs(MIN_Q, MIN_Q, MAX_Q);
		send_coefs(MAX_Q, MAX_Q, MIN_Q);
		send_coefs(MIN_Q, MAX_Q, MIN_Q);
		send_coefs(MAX_Q, MIN_Q, MAX_Q);
		send_coefs(MIN_Q, 0, 0);
		send_coefs(MAX_Q, -1, -1);
		send_coefs(-1, -1, -1);
		send_coefs(1, 1, 0);
		send_coefs(MIN_Q, MIN_Q, MIN_Q);
		send_coefs(MAX_Q, MAX_Q, MAX_Q);
	endtask

	task automatic test_random(int count);
		logic signed [CW-1:0] a, r1, r2;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: send_coefs(0, $urandom, $urandom);
				1, 2: send_coefs($urandom, $urandom, $urandom);
				3, 4, 5: begin
					// built from two known roots so delta stays non-negative unless the products overflow
					a = $signed($urandom) >>> $urandom_range(28, 12);
					if (a == 0)
						a = ONE;
					r1 = $signed($urandom) >>> 22;
					r2 = $signed($urandom) >>> 22;
					send_coefs(a, -(a * (r1 + r2)), a * r1 * r2);
				end
				default: send_coefs(rand_coef(), rand_coef(), rand_coef());
			endcase
		end
	endtask

	task automatic test_backpressure();
		hold_req++;
		test_random(250);
	endtask

	task automatic test_no_idle();
		idle_en = 1'b0;
		test_random(300);
		idle_en = 1'b1;
	endtask

	// sink side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(idle_en && $urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		qer_pkg::roots_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_roots.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h", $time, out_ch.data);
			end else begin
				want = pending_roots.pop_front();
				if (out_ch.data.root_plus !== want.root_plus) begin
					errors++;
					$display("%0t: root_plus exp %h got %h", $time, want.root_plus,
						out_ch.data.root_plus);
				end
				if (out_ch.data.root_minus !== want.root_minus) begin
					errors++;
					$display("%0t: root_minus exp %h got %h", $time, want.root_minus,
						out_ch.data.root_minus);
				end
				if (out_ch.data.status !== want.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, want.status,
						out_ch.data.status);
				end
				if (out_ch.data.saturated !== want.saturated) begin
					errors++;
					$display("%0t: saturated exp %0d got %0d", $time, want.saturated,
						out_ch.data.saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("[quadratic_equation_roots] ERROR");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(650);
		test_backpressure();
		test_no_idle();
		in_ch.valid <= 1'b0;
		wait (pending_roots.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_roots.size() == 0)
			$display("[quadratic_equation_roots] OK");
		else
			$display("[quadratic_equation_roots] ERROR");
		$finish;
	end
endmodule

/* filelist.f */
sv/qer_pkg.sv
sv/qer_chan_if.sv
sv/quadratic_equation_roots.sv
sv/qer_check.sv
tb/tb_quadratic_equation_roots.sv
